FILE: rtl/fra_pkg.sv
// Shared widths, codes and parameter defaults for the fenced ring allocator.
`default_nettype none

package fra_pkg;

    localparam int RING_W  = 25;
    localparam int FENCE_W = 48;
    localparam int ADDR_W  = 64;
    localparam int CFG_W   = 64;

    localparam int MAX_PENDING_DEF = 64;
    localparam int ALIGN_BYTES_DEF = 256;
    localparam int OFFSET_BITS_DEF = 24;

    localparam logic [RING_W-1:0] RING_BYTES_RST = 25'd16777216;

    localparam logic CFG_RING_BYTES   = 1'b0;
    localparam logic CFG_BASE_ADDRESS = 1'b1;

    localparam logic CMD_ALLOC  = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    localparam logic [1:0] ST_GRANT     = 2'd0;
    localparam logic [1:0] ST_WAIT      = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_UPDATE    = 2'd3;

endpackage

`default_nettype wire

FILE: rtl/fenced_ring_allocator_unit.sv
// Fenced ring suballocator: allocate and fence-retire commands over a pending queue memory.
//
// Usage:
//   Commands enter on i_start while o_busy is low; i_cmd selects allocate or
//   fence completion update, with i_request_bytes or i_completed_fence as operand.
//   Every command gives one result, shown for exactly one cycle with o_done high.
//   Allocate: states S_P1, S_P2, S_P3, then S_DEC registers the result; the
//   size rounding runs through a three-stage reciprocal multiply unit.
//   Update: S_RET retires regions up to i_completed_fence; the queue memory
//   pops one entry per cycle through its single registered read port.
//   A new command may be started in the cycle that o_done is high.
//   Configuration: i_cfg_we writes register i_cfg_index (0 ring size,
//   1 base address) from i_cfg_data at once; write only while idle.
//   Reset (synchronous, i_rst_n low) empties the queue, clears the head and
//   fence counter and restores the registers; queue memory contents are kept.
//   The receiver cannot stall; results are never held.
`default_nettype none

module fenced_ring_allocator_unit #(
    parameter int MAX_PENDING = fra_pkg::MAX_PENDING_DEF,
    parameter int ALIGN_BYTES = fra_pkg::ALIGN_BYTES_DEF,
    parameter int OFFSET_BITS = fra_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire logic                              i_cmd,
    input  wire logic [fra_pkg::RING_W-1:0]        i_request_bytes,
    input  wire logic [fra_pkg::FENCE_W-1:0]       i_completed_fence,
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_index,
    input  wire logic [fra_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                                   o_done,
    output logic [1:0]                             o_status,
    output logic [OFFSET_BITS-1:0]                 o_grant_offset,
    output logic [fra_pkg::RING_W-1:0]             o_grant_bytes,
    output logic [fra_pkg::ADDR_W-1:0]             o_grant_address,
    output logic [fra_pkg::FENCE_W-1:0]            o_issued_fence,
    output logic [fra_pkg::FENCE_W-1:0]            o_wait_fence,
    output logic [$clog2(MAX_PENDING+1)-1:0]       o_live_count
);
    import fra_pkg::*;

    localparam int PW  = $clog2(MAX_PENDING);
    localparam int CW  = $clog2(MAX_PENDING+1);
    localparam int OW  = (OFFSET_BITS < RING_W) ? OFFSET_BITS : RING_W;
    localparam int XW  = RING_W + 1;
    localparam int SW  = XW + 1;
    localparam int L   = $clog2(ALIGN_BYTES);
    localparam int SH  = XW + L;
    localparam int MW  = XW + 1;
    localparam int PRW = XW + MW;
    localparam int TW  = XW + $clog2(ALIGN_BYTES + 1);

    localparam logic [MW-1:0]  M0     = MW'((64'd1 << SH) / ALIGN_BYTES);
    localparam logic [XW-1:0]  A_X    = XW'(ALIGN_BYTES);
    localparam logic [XW-1:0]  A_M1   = XW'(ALIGN_BYTES - 1);
    localparam logic           CAP_ON = (OFFSET_BITS < RING_W);
    localparam logic [63:0]    CAP64  = 64'd1 << OFFSET_BITS;
    localparam logic [XW-1:0]  CAP    = CAP_ON ? CAP64[XW-1:0] : '0;
    localparam logic [PW-1:0]  PTR_LAST = PW'(MAX_PENDING - 1);
    localparam logic [CW-1:0]  CNT_MAX  = CW'(MAX_PENDING);

    typedef enum logic [2:0] {
        S_IDLE,
        S_P1,
        S_P2,
        S_P3,
        S_DEC,
        S_RET
    } t_state;

    typedef struct packed {
        logic [OW-1:0]      offset;
        logic [FENCE_W-1:0] fence;
    } t_entry;

    t_state               r_state;
    logic [RING_W-1:0]    r_ring_bytes;
    logic [ADDR_W-1:0]    r_base;
    logic [OW-1:0]        r_head;
    logic [FENCE_W-1:0]   r_fence;
    logic [PW-1:0]        r_rd_ptr;
    logic [PW-1:0]        r_wr_ptr;
    logic [CW-1:0]        r_count;
    logic [FENCE_W-1:0]   r_done_fence;
    logic [ADDR_W-1:0]    r_head_addr;

    t_entry               r_mem [MAX_PENDING];
    t_entry               r_q;
    logic [PW-1:0]        n_rd_ptr;

    logic [XW-1:0]        r_x  [2];
    logic [PRW-1:0]       r_p  [2];
    logic [XW-1:0]        r_t  [2];
    logic [XW-1:0]        r_rd [2];

    logic [XW-1:0]        capped;
    logic                 pop;
    logic [XW-1:0]        size;
    logic [XW-1:0]        aligned;
    logic                 head_ok;
    logic [OW-1:0]        start;
    logic [SW-1:0]        end_s;
    logic [SW-1:0]        tail_x;
    logic                 too_large;
    logic                 ok;
    logic                 at_zero;
    logic [OW-1:0]        offset;
    logic [SW-1:0]        new_head;
    logic [FENCE_W-1:0]   n_fence;
    logic                 commit;

    assign o_busy = (r_state != S_IDLE);

    assign capped = (CAP_ON && (XW'(r_ring_bytes) > CAP)) ? CAP : XW'(r_ring_bytes);

    // rounding unit: lane 0 ring size, lane 1 request; floor to multiple of ALIGN_BYTES
    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_x[0] <= capped;
            r_x[1] <= XW'(i_request_bytes) + A_M1;
        end
        for (int l = 0; l < 2; l++) begin
            r_p[l]  <= PRW'(r_x[l]) * PRW'(M0);
            r_t[l]  <= XW'(TW'(XW'(r_p[l] >> SH)) * TW'(A_X));
            r_rd[l] <= ((r_x[l] - r_t[l]) >= A_X) ? (r_t[l] + A_X) : r_t[l];
        end
    end

    assign pop = (r_state == S_RET) && (r_count != '0) && (r_q.fence <= r_done_fence);

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
    end

    always_comb begin
        size      = r_rd[0];
        aligned   = r_rd[1];
        head_ok   = XW'(r_head) < size;
        start     = head_ok ? r_head : '0;
        end_s     = SW'(start) + SW'(aligned);
        tail_x    = SW'(r_q.offset);
        too_large = aligned > size;
        ok        = 1'b0;
        at_zero   = 1'b0;
        if (r_count >= CNT_MAX) begin
            ok = 1'b0;
        end else if (r_count == '0) begin
            ok      = 1'b1;
            at_zero = end_s > SW'(size);
        end else if (start == r_q.offset) begin
            ok = 1'b0;
        end else if (start > r_q.offset) begin
            if (end_s <= SW'(size)) begin
                ok = 1'b1;
            end else if (SW'(aligned) <= tail_x) begin
                ok      = 1'b1;
                at_zero = 1'b1;
            end
        end else if (end_s <= tail_x) begin
            ok = 1'b1;
        end
        offset   = at_zero ? '0 : start;
        new_head = at_zero ? SW'(aligned) : end_s;
        n_fence  = r_fence + 1'b1;
        commit   = (r_state == S_DEC) && !too_large && ok;
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_mem[r_wr_ptr] <= '{offset: offset, fence: n_fence};
        end
        r_q <= r_mem[n_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_P3) begin
            r_head_addr <= r_base + ADDR_W'(r_head);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ring_bytes <= RING_BYTES_RST;
            r_base       <= '0;
            r_head       <= '0;
            r_fence      <= '0;
            r_rd_ptr     <= '0;
            r_wr_ptr     <= '0;
            r_count      <= '0;
            o_done       <= 1'b0;
        end else begin
            o_done   <= 1'b0;
            r_rd_ptr <= n_rd_ptr;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_RING_BYTES:   r_ring_bytes <= i_cfg_data[RING_W-1:0];
                    CFG_BASE_ADDRESS: r_base       <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_done_fence <= i_completed_fence;
                        r_state      <= (i_cmd == CMD_UPDATE) ? S_RET : S_P1;
                    end
                end
                S_P1: r_state <= S_P2;
                S_P2: r_state <= S_P3;
                S_P3: r_state <= S_DEC;
                S_DEC: begin
                    o_done          <= 1'b1;
                    o_grant_offset  <= '0;
                    o_grant_bytes   <= '0;
                    o_grant_address <= '0;
                    o_issued_fence  <= '0;
                    o_wait_fence    <= '0;
                    o_live_count    <= r_count;
                    r_state         <= S_IDLE;
                    if (too_large) begin
                        o_status <= ST_TOO_LARGE;
                    end else if (!ok) begin
                        o_status     <= ST_WAIT;
                        o_wait_fence <= (r_count != '0) ? r_q.fence : '0;
                    end else begin
                        o_status        <= ST_GRANT;
                        o_grant_offset  <= OFFSET_BITS'(offset);
                        o_grant_bytes   <= aligned[RING_W-1:0];
                        o_grant_address <= (!at_zero && head_ok) ? r_head_addr : r_base;
                        o_issued_fence  <= n_fence;
                        o_live_count    <= r_count + 1'b1;
                        r_head          <= (new_head >= SW'(size)) ? '0 : new_head[OW-1:0];
                        r_fence         <= n_fence;
                        r_wr_ptr        <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
                        r_count         <= r_count + 1'b1;
                    end
                end
                S_RET: begin
                    if (pop) begin
                        r_count <= r_count - 1'b1;
                    end else begin
                        o_done          <= 1'b1;
                        o_status        <= ST_UPDATE;
                        o_grant_offset  <= '0;
                        o_grant_bytes   <= '0;
                        o_grant_address <= '0;
                        o_issued_fence  <= '0;
                        o_wait_fence    <= '0;
                        o_live_count    <= r_count;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("pending count above queue depth");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_grant_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_GRANT)) |-> (o_live_count != '0))
        else $error("grant reported with empty queue");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("command transfer did not raise busy");

endmodule

`default_nettype wire
